// ----- src/epoch_seconds_to_calendar_unit_macros.svh -----
// Assertion macros shared by the epoch seconds to calendar unit.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/esc_pkg.sv -----
// Shared types, constants and functions of the epoch seconds to calendar unit.
package esc_pkg;

    localparam int EPOCH_W = 32;
    localparam int DAYS_W  = 16;

    localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
    localparam logic [6:0]  C100_START      = 7'd70;
    localparam logic [8:0]  C400_START      = 9'd370;
    localparam logic [6:0]  CENTURY_LAST    = 7'd99;
    localparam logic [8:0]  QUAD_CENT_LAST  = 9'd399;
    localparam logic [8:0]  DAYS_YEAR       = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR  = 9'd366;
    localparam logic [4:0]  FEB_DAYS        = 5'd28;
    localparam logic [4:0]  FEB_LEAP_DAYS   = 5'd29;
    localparam logic [3:0]  MONTH_FEB       = 4'd1;
    localparam logic [3:0]  MONTH_DEC       = 4'd11;
    localparam logic [11:0] YEAR_LAST       = 12'd2106;
    localparam logic [6:0]  DIVISOR_MIN_SEC = 7'd60;
    localparam logic [6:0]  DIVISOR_HOUR    = 7'd24;
    localparam logic [6:0]  DIVISOR_WEEK    = 7'd7;
    localparam logic [2:0]  WEEKDAY_OFFSET  = 3'd4;

    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = EPOCH_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    typedef enum logic [1:0] {
        PH_SEC,
        PH_MIN,
        PH_HOUR,
        PH_WDAY
    } div_phase_t;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       div_save;
        div_phase_t phase;
        logic       year_step;
        logic       month_step;
        logic       capture;
    } cmd_t;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } status_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } result_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        case (m)
            MONTH_FEB:                 len = leap ? FEB_LEAP_DAYS : FEB_DAYS;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- src/esc_if.sv -----
// Request and result channel interfaces of the epoch seconds to calendar unit.
interface esc_request_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output weekday,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input weekday,
                    output ready);
endinterface

// ----- src/epoch_seconds_to_calendar_unit.sv -----
// Top level of the epoch seconds to calendar unit.
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into year,
// month, day of month, hour, minute, second and weekday (Sunday is 0). One request is
// handled at a time: the request port is ready only while the unit is idle. A request
// is loaded, then runs four divisions in a shared constant divider at 4 quotient bits
// per cycle, each followed by a save step, then steps the year from 1970 until the
// remaining days fit in it, then steps the month likewise, and last moves the result
// into the output register, the year walk dominating the run time. The output
// register lets a new request be accepted while the previous result still waits to
// be taken.
module epoch_seconds_to_calendar_unit (
    input logic          clk,
    input logic          rst_n,
    esc_request_if.sink  request,
    esc_result_if.source result
);

    esc_pkg::cmd_t    cmd;
    esc_pkg::status_t status;
    esc_pkg::result_t res;

    esc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    esc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .epoch_seconds (request.epoch_seconds),
        .cmd           (cmd),
        .status        (status),
        .res           (res)
    );

    assign result.year         = res.year;
    assign result.month        = res.month;
    assign result.day_of_month = res.day_of_month;
    assign result.hour         = res.hour;
    assign result.minute       = res.minute;
    assign result.second       = res.second;
    assign result.weekday      = res.weekday;

endmodule

// ----- src/esc_datapath.sv -----
// Datapath: constant divider, year and month stepping, and result register.
`include "epoch_seconds_to_calendar_unit_macros.svh"

module esc_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [31:0]               epoch_seconds,
    input  esc_pkg::cmd_t             cmd,
    output esc_pkg::status_t          status,
    output esc_pkg::result_t          res
);

    logic [31:0] q_reg;
    logic [5:0]  rem_reg;
    logic [15:0] days_reg;
    logic [11:0] year_reg;
    logic [6:0]  c100_reg;
    logic [8:0]  c400_reg;
    logic [3:0]  month_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hr_reg;
    logic [2:0]  wd_reg;
    esc_pkg::result_t res_reg;

    logic [6:0]  divisor;
    logic [31:0] div_q;
    logic [5:0]  div_r;
    logic [6:0]  div_t;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    always_comb
    begin
        unique case (cmd.phase)
            esc_pkg::PH_SEC:  divisor = esc_pkg::DIVISOR_MIN_SEC;
            esc_pkg::PH_MIN:  divisor = esc_pkg::DIVISOR_MIN_SEC;
            esc_pkg::PH_HOUR: divisor = esc_pkg::DIVISOR_HOUR;
            default:          divisor = esc_pkg::DIVISOR_WEEK;
        endcase
    end

    // Restoring division, several quotient bits per cycle.
    always_comb
    begin
        div_q = q_reg;
        div_r = rem_reg;
        div_t = '0;
        for (int i = 0; i < esc_pkg::DIV_BITS_PER_CYCLE; i++)
        begin
            div_t = {div_r, div_q[31]};
            if (div_t >= divisor)
            begin
                div_t = div_t - divisor;
                div_q = {div_q[30:0], 1'b1};
            end
            else
            begin
                div_q = {div_q[30:0], 1'b0};
            end
            div_r = div_t[5:0];
        end
    end

    assign leap   = (year_reg[1:0] == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));
    assign ylen   = leap ? esc_pkg::DAYS_LEAP_YEAR : esc_pkg::DAYS_YEAR;
    assign mlen   = esc_pkg::month_len(month_reg, leap);

    assign status.year_fits  = days_reg < {7'd0, ylen};
    assign status.month_fits = days_reg < {11'd0, mlen};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg     <= epoch_seconds;
            rem_reg   <= '0;
            year_reg  <= esc_pkg::EPOCH_YEAR;
            c100_reg  <= esc_pkg::C100_START;
            c400_reg  <= esc_pkg::C400_START;
            month_reg <= '0;
        end
        if (cmd.div_step)
        begin
            q_reg   <= div_q;
            rem_reg <= div_r;
        end
        if (cmd.div_save)
        begin
            rem_reg <= '0;
            unique case (cmd.phase)
                esc_pkg::PH_SEC:  sec_reg <= rem_reg;
                esc_pkg::PH_MIN:  min_reg <= rem_reg;
                esc_pkg::PH_HOUR:
                begin
                    hr_reg   <= rem_reg[4:0];
                    days_reg <= q_reg[15:0];
                    q_reg    <= 32'(q_reg[15:0]) + 32'(esc_pkg::WEEKDAY_OFFSET);
                end
                default:          wd_reg <= rem_reg[2:0];
            endcase
        end
        if (cmd.year_step)
        begin
            days_reg <= days_reg - {7'd0, ylen};
            year_reg <= year_reg + 12'd1;
            c100_reg <= (c100_reg == esc_pkg::CENTURY_LAST) ? 7'd0 : c100_reg + 7'd1;
            c400_reg <= (c400_reg == esc_pkg::QUAD_CENT_LAST) ? 9'd0 : c400_reg + 9'd1;
        end
        if (cmd.month_step)
        begin
            days_reg  <= days_reg - {11'd0, mlen};
            month_reg <= month_reg + 4'd1;
        end
        if (cmd.capture)
        begin
            res_reg.year         <= year_reg;
            res_reg.month        <= month_reg + 4'd1;
            res_reg.day_of_month <= days_reg[4:0] + 5'd1;
            res_reg.hour         <= hr_reg;
            res_reg.minute       <= min_reg;
            res_reg.second       <= sec_reg;
            res_reg.weekday      <= wd_reg;
        end
    end

    assign res = res_reg;

    `ESC_ASSERT_SAME(a_month_in_range, cmd.month_step, month_reg < esc_pkg::MONTH_DEC,
        "month stepping ran past December")
    `ESC_ASSERT_SAME(a_year_in_range, cmd.year_step, year_reg < esc_pkg::YEAR_LAST,
        "year stepping ran past the last representable year")
    `ESC_ASSERT_SAME(a_capture_fits, cmd.capture, status.month_fits,
        "result captured before the day fit in its month")

endmodule

// ----- src/esc_controller.sv -----
// Controller: sequences division, year and month steps and holds result valid.
`include "epoch_seconds_to_calendar_unit_macros.svh"

module esc_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  esc_pkg::status_t    status,
    output esc_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SAVE,
        S_YEAR,
        S_MONTH,
        S_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    esc_pkg::div_phase_t             phase_reg, phase_next;
    logic [esc_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.phase      = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = esc_pkg::PH_SEC;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + esc_pkg::DIV_CNT_W'(1);
                if (cnt_reg == esc_pkg::DIV_CNT_W'(esc_pkg::DIV_CYCLES - 1))
                begin
                    state_next = S_SAVE;
                end
            end
            S_SAVE:
            begin
                cmd.div_save = 1'b1;
                cnt_next     = '0;
                unique case (phase_reg)
                    esc_pkg::PH_SEC:  phase_next = esc_pkg::PH_MIN;
                    esc_pkg::PH_MIN:  phase_next = esc_pkg::PH_HOUR;
                    esc_pkg::PH_HOUR: phase_next = esc_pkg::PH_WDAY;
                    default:          phase_next = esc_pkg::PH_WDAY;
                endcase
                state_next = (phase_reg == esc_pkg::PH_WDAY) ? S_YEAR : S_DIV;
            end
            S_YEAR:
            begin
                if (status.year_fits)
                begin
                    state_next = S_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            S_MONTH:
            begin
                if (status.month_fits)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= esc_pkg::PH_SEC;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ESC_ASSERT_SAME(a_capture_slot_free, cmd.capture, !out_valid_reg || out_ready,
        "result register overwritten while a result was still waiting")
    `ESC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "controller did not start work on an accepted request")
    `ESC_ASSERT_NEXT(a_capture_sets_valid, cmd.capture, out_valid_reg,
        "captured result not presented as valid")

endmodule

// ----- sim/epoch_seconds_to_calendar_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the calendar date of each request and compares the results.
module epoch_seconds_to_calendar_checker (
    input  logic   clk,
    input  logic   rst_n,
    esc_request_if request,
    esc_result_if  result,
    output int     errors,
    output int     pending,
    output int     checked
);

    esc_pkg::result_t expected_dates[$];
    int      mismatches    = 0;
    int      outstanding   = 0;
    int      dates_checked = 0;

    assign errors  = mismatches;
    assign pending = outstanding;
    assign checked = dates_checked;

    function automatic bit has_feb_29(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic esc_pkg::result_t calendar_of(input logic [31:0] secs);
        esc_pkg::result_t date;
        int unsigned t;
        int unsigned days;
        int unsigned yr;
        int unsigned mo;
        int unsigned span;
        t            = secs;
        date.second  = 6'(t % 60);
        t            = t / 60;
        date.minute  = 6'(t % 60);
        t            = t / 60;
        date.hour    = 5'(t % 24);
        days         = t / 24;
        date.weekday = 3'((days + 4) % 7);
        yr   = 1970;
        span = has_feb_29(yr) ? 366 : 365;
        while (days >= span)
        begin
            days = days - span;
            yr   = yr + 1;
            span = has_feb_29(yr) ? 366 : 365;
        end
        mo = 0;
        while (mo < 12)
        begin
            if (mo == 1)
                span = has_feb_29(yr) ? 29 : 28;
            else if (mo == 3 || mo == 5 || mo == 8 || mo == 10)
                span = 30;
            else
                span = 31;
            if (days < span)
                break;
            days = days - span;
            mo   = mo + 1;
        end
        date.year         = 12'(yr);
        date.month        = 4'(mo + 1);
        date.day_of_month = 5'(days + 1);
        return date;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        esc_pkg::result_t got;
        esc_pkg::result_t want;
        if (rst_n)
        begin
            if (request.valid && request.ready)
                expected_dates.push_back(calendar_of(request.epoch_seconds));
            if (result.valid && result.ready)
            begin
                got = {result.year, result.month, result.day_of_month, result.hour,
                       result.minute, result.second, result.weekday};
                if (expected_dates.size() == 0)
                begin
                    $error("Result arrived with no request outstanding.");
                    mismatches++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    compare_field("year", want.year, got.year);
                    compare_field("month", want.month, got.month);
                    compare_field("day_of_month", want.day_of_month, got.day_of_month);
                    compare_field("hour", want.hour, got.hour);
                    compare_field("minute", want.minute, got.minute);
                    compare_field("second", want.second, got.second);
                    compare_field("weekday", want.weekday, got.weekday);
                    dates_checked++;
                end
            end
            outstanding = expected_dates.size();
        end
    end

endmodule

// ----- sim/epoch_seconds_to_calendar_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench top that drives timestamps into the calendar unit and reports the verdict.
module epoch_seconds_to_calendar_unit_test;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    int   checked;
    int   sent = 0;
    int   taken = 0;
    bit   steady = 1'b0;
    bit   stall_done = 1'b0;

    esc_request_if request();
    esc_result_if  result();

    epoch_seconds_to_calendar_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    epoch_seconds_to_calendar_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    always #2 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] to_epoch(input int y, m, d, h, mi, s);
        int     yy;
        int     era;
        int     yoe;
        int     doy;
        int     doe;
        longint days;
        yy   = (m <= 2) ? y - 1 : y;
        era  = yy / 400;
        yoe  = yy - era * 400;
        doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = longint'(era) * 146097 + doe - 719468;
        return 32'(days * 86400 + h * 3600 + mi * 60 + s);
    endfunction

    function automatic logic [31:0] random_timestamp();
        int          pick;
        int          yr;
        logic [31:0] base;
        pick = $urandom_range(99);
        if (pick < 40)
            return $urandom();
        if (pick < 70)
        begin
            base = to_epoch($urandom_range(1970, 2106), $urandom_range(1, 12), 1, 0, 0, 0);
            return base - 32'd172800 + 32'($urandom_range(0, 345600));
        end
        if (pick < 85)
        begin
            yr   = ($urandom_range(7) == 0) ? 2100 : 4 * $urandom_range(493, 526);
            base = to_epoch(yr, 2, 28, 0, 0, 0);
            return base + 32'($urandom_range(0, 3 * 86400 - 1));
        end
        if (pick < 93)
            return 32'($urandom_range(0, 800 * 86400));
        return 32'hFFFF_FFFF - 32'($urandom_range(0, 400 * 86400));
    endfunction

    task automatic offer_timestamp(input logic [31:0] secs);
        if (!steady)
        begin
            while ($urandom_range(99) < 33)
            begin
                request.valid         = 1'b0;
                request.epoch_seconds = $urandom();
                @(negedge clk);
            end
        end
        request.valid         = 1'b1;
        request.epoch_seconds = secs;
        do @(posedge clk); while (!request.ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain_requests();
        request.valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial
    begin
        result.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (taken == 120 && !stall_done)
            begin
                result.ready = 1'b0;
                repeat (800) @(negedge clk);
                stall_done = 1'b1;
            end
            if (taken >= 400 && taken < 560)
                result.ready = 1'b1;
            else
                result.ready = ($urandom_range(99) >= 33);
            @(posedge clk);
            if (result.valid && result.ready)
                taken++;
        end
    end

    initial
    begin
        request.valid         = 1'b0;
        request.epoch_seconds = '0;
        wait (rst_n);
        @(negedge clk);

        offer_timestamp(32'd0);
        offer_timestamp(32'd1);
        offer_timestamp(32'd59);
        offer_timestamp(32'd60);
        offer_timestamp(32'd3599);
        offer_timestamp(32'd3600);
        offer_timestamp(32'd86399);
        offer_timestamp(32'd86400);
        offer_timestamp(to_epoch(1970, 12, 31, 23, 59, 59));
        offer_timestamp(to_epoch(1972, 2, 28, 23, 59, 59));
        offer_timestamp(to_epoch(1972, 2, 29, 12, 30, 30));
        offer_timestamp(to_epoch(1972, 3, 1, 0, 0, 0));
        offer_timestamp(to_epoch(1972, 12, 31, 23, 59, 59));
        offer_timestamp(to_epoch(1973, 1, 1, 0, 0, 0));
        offer_timestamp(to_epoch(2000, 2, 29, 23, 59, 59));
        offer_timestamp(to_epoch(2000, 12, 31, 0, 0, 0));
        offer_timestamp(to_epoch(2100, 2, 28, 23, 59, 59));
        offer_timestamp(to_epoch(2100, 3, 1, 0, 0, 0));
        offer_timestamp(to_epoch(2105, 12, 31, 23, 59, 59));
        offer_timestamp(32'h7FFF_FFFF);
        offer_timestamp(32'h8000_0000);
        offer_timestamp(32'h5555_5555);
        offer_timestamp(32'hAAAA_AAAA);
        offer_timestamp(32'hFFFF_FFFE);
        offer_timestamp(32'hFFFF_FFFF);
        drain_requests();

        for (int i = 0; i < 925; i++)
        begin
            if (i == 650)
                drain_requests();
            steady = (sent >= 400 && sent < 560);
            offer_timestamp(random_timestamp());
        end
        steady = 1'b0;

        request.valid = 1'b0;
        wait (pending == 0);
        repeat (250) @(posedge clk);

        $display("Converted %0d timestamps and checked %0d calendar results,", sent, checked);
        $display("with an 800-cycle output stall and a full drain in the middle of the run.");
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- epoch_seconds_to_calendar_unit.f -----
+incdir+src
src/esc_pkg.sv
src/esc_if.sv
src/esc_datapath.sv
src/esc_controller.sv
src/epoch_seconds_to_calendar_unit.sv
sim/epoch_seconds_to_calendar_checker.sv
sim/epoch_seconds_to_calendar_unit_test.sv
